FILE: hdl/mse_pkg.sv
// shared types and constants for the mips subset execute block
package mse_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RIDX = 5;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // special and special2 function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MTHI = 6'h11;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MTLO = 6'h13;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1A;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_MUL2 = 6'h02;

  // configuration register indexes
  localparam logic CFG_INST_BASE = 1'b0;
  localparam logic CFG_DATA_BASE = 1'b1;

  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic             command;
    logic [XLEN-1:0]  instr_word;
    logic [XLEN-1:0]  load_data;
  } in_item_t;

  typedef struct packed {
    logic [XLEN-1:0]  next_pc;
    logic             mem_read;
    logic             mem_write;
    logic [XLEN-1:0]  mem_address;
    logic [XLEN-1:0]  mem_write_data;
    logic             reg_write;
    logic [RIDX-1:0]  reg_index;
    logic [XLEN-1:0]  reg_value;
    logic             unimplemented;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic rf_rd;      // read operands from the register file
    logic exec;       // evaluate item, commit state or start long op
    logic mul_fin;    // take product into hi/lo (mult) or rd (mul) and finish
    logic div_step;   // one restoring divide iteration
    logic div_fin;    // fix signs and commit quotient/remainder
    logic out_load;   // latch result register
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic div_last;
  } stat_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_EXEC = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_DFIN = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

endpackage

FILE: hdl/mse_stream_if.sv
// valid/ready channel interface for items
interface mse_stream_if #(
  parameter int unsigned Width = 32
) (
  input logic clk_i
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/mse_ram.sv
// generic ram, one write port and two registered read ports
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

FILE: hdl/mse_ctrl.sv
// controller state machine sequencing one item at a time
module mse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  mse_pkg::stat_t stat_i,
  output mse_pkg::ctrl_t ctrl_o
);
  import mse_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        priority if (stat_i.need_mul) state_d = ST_MUL;
        else if (stat_i.need_div) state_d = ST_DIV;
        else state_d = ST_OUT;
      end
      ST_MUL:  state_d = ST_OUT;
      ST_DIV:  if (stat_i.div_last) state_d = ST_DFIN;
      ST_DFIN: state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands
  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = (state_q == ST_OUT);
  assign ctrl_o.rf_rd     = (state_q == ST_IDLE) && in_valid_i;
  assign ctrl_o.exec      = (state_q == ST_EXEC);
  assign ctrl_o.mul_fin   = (state_q == ST_MUL);
  assign ctrl_o.div_step  = (state_q == ST_DIV);
  assign ctrl_o.div_fin   = (state_q == ST_DFIN);
  assign ctrl_o.out_load  = (state_q == ST_EXEC);
endmodule

FILE: hdl/mse_datapath.sv
// datapath: register file, alu, hi/lo, pc, multiplier and serial divider
module mse_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [mse_pkg::XLEN-1:0]     cfg_data_i,
  input  mse_pkg::in_item_t            item_i,
  input  mse_pkg::ctrl_t               ctrl_i,
  output mse_pkg::stat_t               stat_o,
  output mse_pkg::out_item_t           result_o
);
  import mse_pkg::*;

  logic [XLEN-1:0] data_base_q, pc_q, hi_q, lo_q;
  logic [RIDX-1:0] load_dest_q;
  logic            load_pending_q;
  in_item_t        item_q;
  out_item_t       res_q, res_d, res_ld;

  // register file valid bits stand for the all-zero reset
  logic [31:0]     rf_vld_q;
  logic [RIDX-1:0] ra_q, rb_q;
  logic [XLEN-1:0] rf_a_raw, rf_b_raw, a, b;
  logic            rf_we;
  logic [RIDX-1:0] rf_waddr;
  logic [XLEN-1:0] rf_wdata;

  // decode fields
  logic [5:0]      op, fn;
  logic [RIDX-1:0] rs, rt, rd, sh;
  logic [XLEN-1:0] simm, zimm, p, btgt, jtgt, esum, eaddr;
  assign op   = item_q.instr_word[31:26];
  assign rs   = item_q.instr_word[25:21];
  assign rt   = item_q.instr_word[20:16];
  assign rd   = item_q.instr_word[15:11];
  assign sh   = item_q.instr_word[10:6];
  assign fn   = item_q.instr_word[5:0];
  assign simm = {{16{item_q.instr_word[15]}}, item_q.instr_word[15:0]};
  assign zimm = {16'h0000, item_q.instr_word[15:0]};
  assign p    = pc_q + 32'd4;
  assign btgt = p + {simm[29:0], 2'b00};
  assign jtgt = {p[31:28], item_q.instr_word[25:0], 2'b00};
  assign esum = a + simm;
  assign eaddr = data_base_q + {2'b00, esum[31:2]};

  // operand read: addresses from the captured item
  mse_ram #(.Width(XLEN), .Depth(32)) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .raddr_a_i (ra_q),
    .raddr_b_i (rb_q),
    .rdata_a_o (rf_a_raw),
    .rdata_b_o (rf_b_raw)
  );

  assign a = rf_vld_q[ra_q] ? rf_a_raw : '0;
  assign b = rf_vld_q[rb_q] ? rf_b_raw : '0;

  // item capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rf_rd) begin
      item_q <= item_i;
      ra_q   <= item_i.instr_word[25:21];
      rb_q   <= item_i.instr_word[20:16];
    end
  end

  // main evaluation
  logic            wen, unimp, npc_chg, set_hi, set_lo, ld_set, ld_clr;
  logic [XLEN-1:0] hi_new, lo_new;
  logic            need_mul, need_div;
  always_comb begin
    res_d    = '0;
    res_d.next_pc = pc_q;
    wen      = 1'b0;
    unimp    = 1'b0;
    npc_chg  = 1'b0;
    set_hi   = 1'b0;
    set_lo   = 1'b0;
    hi_new   = a;
    lo_new   = a;
    ld_set   = 1'b0;
    ld_clr   = 1'b0;
    need_mul = 1'b0;
    need_div = 1'b0;
    if (item_q.command == CMD_LOAD) begin
      if (load_pending_q) begin
        wen = 1'b1;
        res_d.reg_index = load_dest_q;
        res_d.reg_value = item_q.load_data;
        ld_clr = 1'b1;
      end
    end else begin
      npc_chg = 1'b1;
      res_d.next_pc = p;
      unique case (op)
        OP_SPECIAL: begin
          res_d.reg_index = rd;
          unique case (fn)
            FN_ADD, FN_ADDU: begin wen = 1'b1; res_d.reg_value = a + b; end
            FN_SUB, FN_SUBU: begin wen = 1'b1; res_d.reg_value = a - b; end
            FN_AND:  begin wen = 1'b1; res_d.reg_value = a & b; end
            FN_OR:   begin wen = 1'b1; res_d.reg_value = a | b; end
            FN_XOR:  begin wen = 1'b1; res_d.reg_value = a ^ b; end
            FN_NOR:  begin wen = 1'b1; res_d.reg_value = ~(a | b); end
            FN_SLT:  begin
              wen = 1'b1;
              res_d.reg_value = {31'd0, $signed(a) < $signed(b)};
            end
            FN_SLL:  begin wen = 1'b1; res_d.reg_value = b << sh; end
            FN_SRL:  begin wen = 1'b1; res_d.reg_value = b >> sh; end
            FN_SRA:  begin wen = 1'b1; res_d.reg_value = $unsigned($signed(b) >>> sh); end
            FN_MFHI: begin wen = 1'b1; res_d.reg_value = hi_q; end
            FN_MFLO: begin wen = 1'b1; res_d.reg_value = lo_q; end
            FN_JR:   res_d.next_pc = a;
            FN_MTHI: set_hi = 1'b1;
            FN_MTLO: set_lo = 1'b1;
            FN_MULT: need_mul = 1'b1;
            FN_DIV:  need_div = (b != '0);
            default: unimp = 1'b1;
          endcase
        end
        OP_REGIMM: begin
          priority if (rt == 5'd0) begin
            if (a[31]) res_d.next_pc = btgt;
          end else if (rt == 5'd1) begin
            if (!a[31]) res_d.next_pc = btgt;
          end else begin
            unimp = 1'b1;
          end
        end
        OP_SPECIAL2: begin
          if (fn == FN_MUL2) begin
            need_mul = 1'b1;
            res_d.reg_index = rd;
          end else begin
            unimp = 1'b1;
          end
        end
        OP_BEQ: if (a == b) res_d.next_pc = btgt;
        OP_BNE: if (a != b) res_d.next_pc = btgt;
        OP_ADDI, OP_ADDIU: begin
          wen = 1'b1; res_d.reg_index = rt; res_d.reg_value = a + simm;
        end
        OP_SLTI: begin
          wen = 1'b1; res_d.reg_index = rt;
          res_d.reg_value = {31'd0, $signed(a) < $signed(simm)};
        end
        OP_SLTIU: begin
          wen = 1'b1; res_d.reg_index = rt; res_d.reg_value = {31'd0, a < simm};
        end
        OP_ANDI: begin wen = 1'b1; res_d.reg_index = rt; res_d.reg_value = a & zimm; end
        OP_ORI:  begin wen = 1'b1; res_d.reg_index = rt; res_d.reg_value = a | zimm; end
        OP_XORI: begin wen = 1'b1; res_d.reg_index = rt; res_d.reg_value = a ^ zimm; end
        OP_J:    res_d.next_pc = jtgt;
        OP_JAL: begin
          res_d.next_pc = jtgt;
          wen = 1'b1; res_d.reg_index = 5'd31; res_d.reg_value = p;
        end
        OP_LW: begin
          res_d.mem_read = 1'b1;
          res_d.mem_address = eaddr;
          ld_set = 1'b1;
        end
        OP_SW: begin
          res_d.mem_write = 1'b1;
          res_d.mem_address = eaddr;
          res_d.mem_write_data = b;
        end
        default: unimp = 1'b1;
      endcase
    end
    res_d.unimplemented = unimp;
    res_d.reg_write = wen && (res_d.reg_index != '0);
    if (!res_d.reg_write) begin
      res_d.reg_index = '0;
      res_d.reg_value = '0;
    end
  end

  assign stat_o.need_mul = need_mul;
  assign stat_o.need_div = need_div;

  // signed multiply registered into a product, then finished
  logic [2*XLEN-1:0]        prod_q;
  logic signed [2*XLEN-1:0] prod_s;
  logic                     mul_is_mult_q;
  assign prod_s = $signed(a) * $signed(b);
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      prod_q        <= $unsigned(prod_s);
      mul_is_mult_q <= (op == OP_SPECIAL);
    end
  end

  // restoring divider on magnitudes, one bit per cycle
  logic [XLEN-1:0] dq_q, dr_q, dd_q;
  logic [5:0]      dcnt_q;
  logic            qneg_q, rneg_q;
  logic [XLEN:0]   trial;
  logic [XLEN-1:0] rshift;
  assign rshift = {dr_q[XLEN-2:0], dq_q[XLEN-1]};
  assign trial  = {dr_q, dq_q[XLEN-1]} - {1'b0, dd_q};
  assign stat_o.div_last = (dcnt_q == 6'd31);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      dq_q   <= a[31] ? (32'd0 - a) : a;
      dd_q   <= b[31] ? (32'd0 - b) : b;
      dr_q   <= '0;
      dcnt_q <= '0;
      qneg_q <= a[31] ^ b[31];
      rneg_q <= a[31];
    end else if (ctrl_i.div_step) begin
      dcnt_q <= dcnt_q + 6'd1;
      if (!trial[XLEN]) begin
        dr_q <= trial[XLEN-1:0];
        dq_q <= {dq_q[XLEN-2:0], 1'b1};
      end else begin
        dr_q <= rshift;
        dq_q <= {dq_q[XLEN-2:0], 1'b0};
      end
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_base_q    <= '0;
      pc_q           <= '0;
      hi_q           <= '0;
      lo_q           <= '0;
      load_dest_q    <= '0;
      load_pending_q <= 1'b0;
      rf_vld_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INST_BASE) pc_q <= cfg_data_i;
        else data_base_q <= cfg_data_i;
      end
      if (ctrl_i.exec) begin
        if (npc_chg) pc_q <= res_d.next_pc;
        if (set_hi) hi_q <= hi_new;
        if (set_lo) lo_q <= lo_new;
        if (ld_set) begin
          load_dest_q    <= rt;
          load_pending_q <= 1'b1;
        end
        if (ld_clr) load_pending_q <= 1'b0;
      end
      if (ctrl_i.mul_fin && mul_is_mult_q) begin
        hi_q <= prod_q[2*XLEN-1:XLEN];
        lo_q <= prod_q[XLEN-1:0];
      end
      if (ctrl_i.div_fin) begin
        lo_q <= qneg_q ? (32'd0 - dq_q) : dq_q;
        hi_q <= rneg_q ? (32'd0 - dr_q) : dr_q;
      end
      if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
    end
  end

  // register file write: normal results at exec, mul at its finish
  logic mul_wr;
  assign mul_wr   = ctrl_i.mul_fin && !mul_is_mult_q && (res_q.reg_index != '0);
  assign rf_we    = (ctrl_i.exec && res_d.reg_write) || mul_wr;
  assign rf_waddr = mul_wr ? res_q.reg_index : res_d.reg_index;
  assign rf_wdata = mul_wr ? prod_q[XLEN-1:0] : res_d.reg_value;

  // result as loaded, mul keeps its destination for the finish step
  always_comb begin
    res_ld = res_d;
    if (need_mul && op == OP_SPECIAL2) res_ld.reg_index = rd;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      res_q <= res_ld;
    end else if (mul_wr) begin
      res_q.reg_write <= 1'b1;
      res_q.reg_value <= prod_q[XLEN-1:0];
    end else if (ctrl_i.mul_fin) begin
      res_q.reg_index <= '0;
    end
  end

  assign result_o = res_q;
endmodule

FILE: hdl/mips_subset_execute.sv
// top level of the mips subset execute block
// each item is read, executed, then offered; mult and mul add a finish step, div
// with a nonzero divisor a serial divide (one quotient bit a cycle) and a sign fix
// one item at a time; next input can be taken the cycle after result transfer
// reset: asynchronous active low; registers, hi, lo, pc and bases clear to zero
// the register file reads as zero until each entry is first written
module mips_subset_execute (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  mse_stream_if.sink               in_if,
  mse_stream_if.source             out_if
);
  import mse_pkg::*;

  ctrl_t     ctrl;
  stat_t     stat;
  out_item_t result;
  in_item_t  item;

  assign item = in_item_t'(in_if.payload);

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mse_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .result_o   (result)
  );

  assign out_if.payload = result;
endmodule

FILE: hdl/mse_checker.sv
// port level checks bound to the top level
module mse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [136:0] out_payload
);
  // no input taken while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // a result stays until transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result dropped");
  // input transfer gives no result in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
  // after a result transfer the block is ready again
  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> in_ready) else $error("not ready after transfer");
endmodule

bind mips_subset_execute mse_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_payload (out_if.payload)
);
